### design/qvr_pkg.sv
// Shared widths, types and register indexes for the quaternion vector rotation block.
package qvr_pkg;

  localparam int COORD_WIDTH    = 24;
  localparam int QUAT_FRAC_BITS = 16;
  localparam int QUAT_WIDTH     = QUAT_FRAC_BITS + 2;
  localparam int GUARD_BITS     = 2;

  // first product q * (0, v)
  localparam int PROD1_W = QUAT_WIDTH + COORD_WIDTH;
  localparam int SUM1_W  = PROD1_W + 2;
  localparam int SHIFT1  = QUAT_FRAC_BITS - GUARD_BITS;
  localparam int T_W     = SUM1_W - SHIFT1;

  // second product t * conj(q)
  localparam int PROD2_W = T_W + QUAT_WIDTH;
  localparam int SUM2_W  = PROD2_W + 2;
  localparam int SHIFT2  = QUAT_FRAC_BITS + GUARD_BITS;
  localparam int R_W     = SUM2_W - SHIFT2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = 3'd3;

  typedef struct packed {
    logic signed [QUAT_WIDTH-1:0] w;
    logic signed [QUAT_WIDTH-1:0] x;
    logic signed [QUAT_WIDTH-1:0] y;
    logic signed [QUAT_WIDTH-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } cvec_t;

  typedef struct packed {
    logic signed [T_W-1:0] t0;
    logic signed [T_W-1:0] t1;
    logic signed [T_W-1:0] t2;
    logic signed [T_W-1:0] t3;
  } tquat_t;

  typedef struct packed {
    logic signed [R_W-1:0] x;
    logic signed [R_W-1:0] y;
    logic signed [R_W-1:0] z;
  } rvec_t;

endpackage

### design/qvr_fwd_prod.sv
// Two pipeline stages forming t = q * (0, v), rounded to guard-bit scale.
module qvr_fwd_prod (
  input  logic           clk,
  input  logic           rst_n,
  input  qvr_pkg::quat_t q,
  input  logic           in_valid,
  output logic           in_ready,
  input  qvr_pkg::cvec_t vec,
  output logic           out_valid,
  input  logic           out_ready,
  output qvr_pkg::tquat_t t
);

  localparam logic signed [qvr_pkg::SUM1_W-1:0] RND =
    qvr_pkg::SUM1_W'(1) << (qvr_pkg::SHIFT1 - 1);

  logic signed [qvr_pkg::PROD1_W-1:0] p_nxt [12];
  logic signed [qvr_pkg::PROD1_W-1:0] p_r   [12];
  logic signed [qvr_pkg::SUM1_W-1:0]  s_nxt [4];
  qvr_pkg::tquat_t t_nxt;
  qvr_pkg::tquat_t t_r;
  logic a_vld_r, b_vld_r;
  logic a_rdy, b_rdy;

  assign b_rdy    = !b_vld_r || out_ready;
  assign a_rdy    = !a_vld_r || b_rdy;
  assign in_ready = a_rdy;

  always_comb begin
    p_nxt[0]  = q.x * vec.x;
    p_nxt[1]  = q.y * vec.y;
    p_nxt[2]  = q.z * vec.z;
    p_nxt[3]  = q.w * vec.x;
    p_nxt[4]  = q.y * vec.z;
    p_nxt[5]  = q.z * vec.y;
    p_nxt[6]  = q.w * vec.y;
    p_nxt[7]  = q.x * vec.z;
    p_nxt[8]  = q.z * vec.x;
    p_nxt[9]  = q.w * vec.z;
    p_nxt[10] = q.x * vec.y;
    p_nxt[11] = q.y * vec.x;
  end

  always_comb begin
    s_nxt[0] = -qvr_pkg::SUM1_W'(p_r[0]) - qvr_pkg::SUM1_W'(p_r[1])
               - qvr_pkg::SUM1_W'(p_r[2]) + RND;
    s_nxt[1] = qvr_pkg::SUM1_W'(p_r[3]) + qvr_pkg::SUM1_W'(p_r[4])
               - qvr_pkg::SUM1_W'(p_r[5]) + RND;
    s_nxt[2] = qvr_pkg::SUM1_W'(p_r[6]) - qvr_pkg::SUM1_W'(p_r[7])
               + qvr_pkg::SUM1_W'(p_r[8]) + RND;
    s_nxt[3] = qvr_pkg::SUM1_W'(p_r[9]) + qvr_pkg::SUM1_W'(p_r[10])
               - qvr_pkg::SUM1_W'(p_r[11]) + RND;
    // floor shift, sum range leaves top bits as pure sign
    t_nxt.t0 = qvr_pkg::T_W'(s_nxt[0] >>> qvr_pkg::SHIFT1);
    t_nxt.t1 = qvr_pkg::T_W'(s_nxt[1] >>> qvr_pkg::SHIFT1);
    t_nxt.t2 = qvr_pkg::T_W'(s_nxt[2] >>> qvr_pkg::SHIFT1);
    t_nxt.t3 = qvr_pkg::T_W'(s_nxt[3] >>> qvr_pkg::SHIFT1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_rdy) a_vld_r <= in_valid;
      if (b_rdy) b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) p_r <= p_nxt;
    if (b_rdy && a_vld_r) t_r <= t_nxt;
  end

  assign out_valid = b_vld_r;
  assign t         = t_r;

endmodule

### design/qvr_conj_prod.sv
// Two pipeline stages forming the vector part of t * conj(q), rounded to coordinate scale.
module qvr_conj_prod (
  input  logic            clk,
  input  logic            rst_n,
  input  qvr_pkg::quat_t  q,
  input  logic            in_valid,
  output logic            in_ready,
  input  qvr_pkg::tquat_t t,
  output logic            out_valid,
  input  logic            out_ready,
  output qvr_pkg::rvec_t  r
);

  localparam logic signed [qvr_pkg::SUM2_W-1:0] RND =
    qvr_pkg::SUM2_W'(1) << (qvr_pkg::SHIFT2 - 1);

  logic signed [qvr_pkg::PROD2_W-1:0] p_nxt [12];
  logic signed [qvr_pkg::PROD2_W-1:0] p_r   [12];
  logic signed [qvr_pkg::SUM2_W-1:0]  s_nxt [3];
  qvr_pkg::rvec_t r_nxt;
  qvr_pkg::rvec_t r_r;
  logic a_vld_r, b_vld_r;
  logic a_rdy, b_rdy;

  assign b_rdy    = !b_vld_r || out_ready;
  assign a_rdy    = !a_vld_r || b_rdy;
  assign in_ready = a_rdy;

  always_comb begin
    p_nxt[0]  = t.t1 * q.w;
    p_nxt[1]  = t.t0 * q.x;
    p_nxt[2]  = t.t3 * q.y;
    p_nxt[3]  = t.t2 * q.z;
    p_nxt[4]  = t.t2 * q.w;
    p_nxt[5]  = t.t0 * q.y;
    p_nxt[6]  = t.t1 * q.z;
    p_nxt[7]  = t.t3 * q.x;
    p_nxt[8]  = t.t3 * q.w;
    p_nxt[9]  = t.t0 * q.z;
    p_nxt[10] = t.t2 * q.x;
    p_nxt[11] = t.t1 * q.y;
  end

  always_comb begin
    s_nxt[0] = qvr_pkg::SUM2_W'(p_r[0]) - qvr_pkg::SUM2_W'(p_r[1])
               + qvr_pkg::SUM2_W'(p_r[2]) - qvr_pkg::SUM2_W'(p_r[3]) + RND;
    s_nxt[1] = qvr_pkg::SUM2_W'(p_r[4]) - qvr_pkg::SUM2_W'(p_r[5])
               + qvr_pkg::SUM2_W'(p_r[6]) - qvr_pkg::SUM2_W'(p_r[7]) + RND;
    s_nxt[2] = qvr_pkg::SUM2_W'(p_r[8]) - qvr_pkg::SUM2_W'(p_r[9])
               + qvr_pkg::SUM2_W'(p_r[10]) - qvr_pkg::SUM2_W'(p_r[11]) + RND;
    r_nxt.x = qvr_pkg::R_W'(s_nxt[0] >>> qvr_pkg::SHIFT2);
    r_nxt.y = qvr_pkg::R_W'(s_nxt[1] >>> qvr_pkg::SHIFT2);
    r_nxt.z = qvr_pkg::R_W'(s_nxt[2] >>> qvr_pkg::SHIFT2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_rdy) a_vld_r <= in_valid;
      if (b_rdy) b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) p_r <= p_nxt;
    if (b_rdy && a_vld_r) r_r <= r_nxt;
  end

  assign out_valid = b_vld_r;
  assign r         = r_r;

endmodule

### design/qvr_sat.sv
// Output stage: clips each rotated component to the coordinate range and flags clipping.
module qvr_sat (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  qvr_pkg::rvec_t r,
  output logic           out_valid,
  input  logic           out_ready,
  output qvr_pkg::cvec_t rot,
  output logic           sat
);

  localparam logic signed [qvr_pkg::R_W-1:0] HI =
    {{(qvr_pkg::R_W - qvr_pkg::COORD_WIDTH + 1){1'b0}},
     {(qvr_pkg::COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [qvr_pkg::R_W-1:0] LO = ~HI;

  qvr_pkg::cvec_t rot_nxt, rot_r;
  logic [2:0] clip_hi, clip_lo;
  logic sat_nxt, sat_r;
  logic vld_r;

  assign in_ready = !vld_r || out_ready;

  always_comb begin
    clip_hi = {r.x > HI, r.y > HI, r.z > HI};
    clip_lo = {r.x < LO, r.y < LO, r.z < LO};
    rot_nxt.x = clip_hi[2] ? HI[qvr_pkg::COORD_WIDTH-1:0] :
                clip_lo[2] ? LO[qvr_pkg::COORD_WIDTH-1:0] :
                             r.x[qvr_pkg::COORD_WIDTH-1:0];
    rot_nxt.y = clip_hi[1] ? HI[qvr_pkg::COORD_WIDTH-1:0] :
                clip_lo[1] ? LO[qvr_pkg::COORD_WIDTH-1:0] :
                             r.y[qvr_pkg::COORD_WIDTH-1:0];
    rot_nxt.z = clip_hi[0] ? HI[qvr_pkg::COORD_WIDTH-1:0] :
                clip_lo[0] ? LO[qvr_pkg::COORD_WIDTH-1:0] :
                             r.z[qvr_pkg::COORD_WIDTH-1:0];
    sat_nxt = |{clip_hi, clip_lo};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rot_r <= rot_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_valid = vld_r;
  assign rot       = rot_r;
  assign sat       = sat_r;

endmodule

### design/quaternion_vector_rotation_top.sv
// Top level of the quaternion vector rotation block: config registers and pipeline.
//
// Rotates each incoming signed Q11.12 vector by the unit quaternion held in the
// four Q1.16 registers (quat_w, quat_x, quat_y, quat_z at indexes 0..3; reset is
// the identity rotation), computing q * (0, v) * conj(q) with no renormalization.
// Results are rounded to nearest (ties toward plus infinity) and clipped to the
// 24-bit range, with out_saturated set when any component was clipped. The block
// accepts one transaction per cycle while out_ready stays high, and each result
// passes through registered stages in turn: two for the first quaternion
// product (multiply, then sum and round), two for the second, one for clipping.
// Each stage holds one transaction; stalls back up stage by stage so no
// transaction is lost or repeated, and in_ready stays high while any stage has
// room. Write the quaternion only while the pipeline is empty; writes to indexes
// beyond 3 are ignored. cfg_ready is always high.
module quaternion_vector_rotation_top (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // configuration write channel
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [qvr_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [qvr_pkg::QUAT_WIDTH-1:0]          cfg_data,
  // input vectors
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [qvr_pkg::COORD_WIDTH-1:0]  in_vec_x,
  input  logic signed [qvr_pkg::COORD_WIDTH-1:0]  in_vec_y,
  input  logic signed [qvr_pkg::COORD_WIDTH-1:0]  in_vec_z,
  // rotated vectors
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [qvr_pkg::COORD_WIDTH-1:0]  out_rot_x,
  output logic signed [qvr_pkg::COORD_WIDTH-1:0]  out_rot_y,
  output logic signed [qvr_pkg::COORD_WIDTH-1:0]  out_rot_z,
  output logic                                    out_saturated
);

  qvr_pkg::quat_t  quat_r;
  qvr_pkg::cvec_t  vec_in;
  qvr_pkg::cvec_t  rot;
  qvr_pkg::tquat_t t;
  qvr_pkg::rvec_t  r;
  logic t_valid, t_ready;
  logic r_valid, r_ready;

  assign cfg_ready = 1'b1;

  // quaternion registers, identity at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r.w <= qvr_pkg::QUAT_WIDTH'(1) << qvr_pkg::QUAT_FRAC_BITS;
      quat_r.x <= '0;
      quat_r.y <= '0;
      quat_r.z <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qvr_pkg::REG_QUAT_W: quat_r.w <= cfg_data;
        qvr_pkg::REG_QUAT_X: quat_r.x <= cfg_data;
        qvr_pkg::REG_QUAT_Y: quat_r.y <= cfg_data;
        qvr_pkg::REG_QUAT_Z: quat_r.z <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign vec_in.x = in_vec_x;
  assign vec_in.y = in_vec_y;
  assign vec_in.z = in_vec_z;

  // t = q * (0, v)
  qvr_fwd_prod u_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .q         (quat_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .vec       (vec_in),
    .out_valid (t_valid),
    .out_ready (t_ready),
    .t         (t)
  );

  // vector part of t * conj(q)
  qvr_conj_prod u_conj (
    .clk       (clk),
    .rst_n     (rst_n),
    .q         (quat_r),
    .in_valid  (t_valid),
    .in_ready  (t_ready),
    .t         (t),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .r         (r)
  );

  // clip and output register
  qvr_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (r_valid),
    .in_ready  (r_ready),
    .r         (r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rot       (rot),
    .sat       (out_saturated)
  );

  assign out_rot_x = rot.x;
  assign out_rot_y = rot.y;
  assign out_rot_z = rot.z;

endmodule
